/* rtl/integer_to_decimal_ascii_macros.svh */
// Assertion macros used by the checker of this block.
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITDA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itda check failed");

// Consequent checked in the cycle after the antecedent.
`define ITDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itda check failed");

`endif

/* rtl/itda_pkg.sv */
package itda_pkg;

   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 7;
   localparam int TEXT_MAX = 20;
   localparam int BCD_W    = 4 * TEXT_MAX;
   localparam int BIT_CNT_W = $clog2(VALUE_W);
   localparam int DIG_CNT_W = $clog2(TEXT_MAX + 1);

   localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(VALUE_W - 1);
   localparam logic [DIG_CNT_W-1:0] DIG_CNT_FULL = DIG_CNT_W'(TEXT_MAX);
   localparam logic [DIG_CNT_W-1:0] DIG_CNT_ONE  = DIG_CNT_W'(1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

   typedef struct packed {
      logic [VALUE_W-1:0] value_bits;
      logic               is_signed;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              is_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_DABBLE,
      OP_DIGIT
   } bcd_op_type;

   typedef struct packed {
      bcd_op_type         op;
      logic [VALUE_W-1:0] load_value;
   } bcd_ctrl_type;

endpackage

/* rtl/itda_bcd_unit.sv */
module itda_bcd_unit import itda_pkg::*; (
   input  logic               clock,
   input  bcd_ctrl_type       ctrl,
   output logic [3:0]         top_digit
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < TEXT_MAX; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            bin_in = ctrl.load_value;
            bcd_in = '0;
         end
         OP_DABBLE: begin
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         end
         OP_DIGIT: begin
            bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

/* rtl/integer_to_decimal_ascii.sv */
// Sequence: after a request the BCD unit runs 64 shift-add-3 steps, then leading zeros
//   are dropped; with a leading minus sign the sign is sent before the first digit.
// A new request is taken only in idle, after the last character has been loaded;
//   the one BCD unit does both the conversion steps and the digit shifting.
// Reset: synchronous, active high; returns to idle and drops any pending character.
module integer_to_decimal_ascii import itda_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   bcd_ctrl_type           ctrl;
   logic [3:0]             top_digit;
   logic                   req_accept;
   logic                   out_free;
   logic                   rsp_load;
   rsp_type                rsp_next;
   logic                   req_neg;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_neg    = req_data.is_signed && req_data.value_bits[VALUE_W-1];

   itda_bcd_unit u_bcd (
      .clock     (clock),
      .ctrl      (ctrl),
      .top_digit (top_digit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bit_cnt_ff == BIT_CNT_LAST) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!(top_digit == 4'd0 && dig_cnt_ff != DIG_CNT_ONE)) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && dig_cnt_ff == DIG_CNT_ONE) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctrl.op         = OP_HOLD;
      ctrl.load_value = req_neg ? (~req_data.value_bits + VALUE_W'(1))
                                : req_data.value_bits;
      req_stall       = 1'b1;
      rsp_load        = 1'b0;
      rsp_next.text_char = CHAR_ZERO + {3'd0, top_digit};
      rsp_next.is_last   = (dig_cnt_ff == DIG_CNT_ONE);
      bit_cnt_in      = bit_cnt_ff;
      dig_cnt_in      = dig_cnt_ff;
      neg_in          = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               ctrl.op    = OP_LOAD;
               bit_cnt_in = '0;
               dig_cnt_in = DIG_CNT_FULL;
               neg_in     = req_neg;
            end
         end
         ST_CONV: begin
            ctrl.op    = OP_DABBLE;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == 4'd0 && dig_cnt_ff != DIG_CNT_ONE) begin
               ctrl.op    = OP_DIGIT;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end
         end
         ST_SIGN: begin
            rsp_next.text_char = CHAR_MINUS;
            rsp_next.is_last   = 1'b0;
            rsp_load           = out_free;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               ctrl.op    = OP_DIGIT;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_data_in  = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/itda_checker.sv */
`include "integer_to_decimal_ascii_macros.svh"

module itda_checker import itda_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `ITDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ITDA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   `ITDA_ASSERT_SAME(a_minus_not_last, clock, reset, rsp_valid && rsp_data.text_char == CHAR_MINUS, !rsp_data.is_last)
   `ITDA_ASSERT_SAME(a_char_legal, clock, reset, rsp_valid, rsp_data.text_char == CHAR_MINUS || (rsp_data.text_char >= CHAR_ZERO && rsp_data.text_char <= CHAR_NINE))

endmodule

bind integer_to_decimal_ascii itda_checker u_itda_checker (.*);
